[hw/rtl/assert_macros.svh]
// Assertion helpers included by fair_share_debt_update.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FSDU_ASSERT_IMP(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |-> (c)) \
    else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define FSDU_ASSERT_NXT(lbl, ck, rn, a, c) \
  lbl: assert property (@(posedge ck) disable iff (!rn) (a) |=> (c)) \
    else $error("next-cycle implication check failed");

`endif

[hw/rtl/fsdu_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsdu_pkg
// Widths, limits and shared types of the fair-share debt update block.
// ----------------------------------------------------------------------------
package fsdu_pkg;

  localparam int SLOT_W   = 4;
  localparam int WALL_W   = 32;
  localparam int WEIGHT_W = 16;
  localparam int TP_W     = 22;
  localparam int SHORT_W  = 26;
  localparam int LONG_W   = 48;
  localparam int A_W      = 38;   // sum of up to 64 used times
  localparam int PROD_W   = 54;   // used-time sum times weight
  localparam int DVSR_W   = 22;
  localparam int RW_W     = 22;   // sum of runnable weights
  localparam int NRUN_W   = 7;
  localparam int LSUM_W   = 56;
  localparam int TMP_W    = 40;   // short debt before the mean is removed
  localparam int TOT_W    = 47;
  localparam int DIFF_W   = 48;
  localparam int CNT_W    = 6;

  localparam logic signed [LSUM_W-1:0] LONG_HI =
      (LSUM_W'(1) <<< (LONG_W - 1)) - LSUM_W'(1);
  localparam logic signed [LSUM_W-1:0] LONG_LO = -(LSUM_W'(1) <<< (LONG_W - 1));
  localparam logic signed [DIFF_W-1:0] SHORT_HI = DIFF_W'(86400 * 256);
  localparam logic signed [DIFF_W-1:0] SHORT_LO = -DIFF_W'(86400 * 256);

  typedef enum logic {
    FUNC_LOAD  = 1'b0,
    FUNC_CLEAR = 1'b1
  } func_t;

  typedef struct packed {
    logic                runnable;
    logic [WEIGHT_W-1:0] weight;
    logic [WALL_W-1:0]   used;
  } ent_t;

  typedef struct packed {
    logic              go;
    logic [PROD_W-1:0] dividend;
    logic [DVSR_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic              busy;
    logic              done;
    logic [PROD_W-1:0] quotient;
  } div_rsp_t;

endpackage
`default_nettype wire

[hw/rtl/fsdu_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsdu_in_if
// Input channel: one project entry or a clear command per transfer.
// ----------------------------------------------------------------------------
interface fsdu_in_if;
  logic        valid;
  logic        ready;
  logic        func;
  logic [3:0]  slot;
  logic [31:0] wall_time;
  logic [15:0] share_weight;
  logic        runnable;
  logic        round_end;

  modport source (output valid, func, slot, wall_time, share_weight, runnable, round_end,
                  input ready);
  modport sink (input valid, func, slot, wall_time, share_weight, runnable, round_end,
                output ready);
endinterface
`default_nettype wire

[hw/rtl/fsdu_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsdu_out_if
// Result channel: the debts of one slot per transfer.
// ----------------------------------------------------------------------------
interface fsdu_out_if;
  logic               valid;
  logic               ready;
  logic [3:0]         out_slot;
  logic signed [25:0] out_short;
  logic signed [47:0] out_long;
  logic               last_out;

  modport source (output valid, out_slot, out_short, out_long, last_out, input ready);
  modport sink (input valid, out_slot, out_short, out_long, last_out, output ready);
endinterface
`default_nettype wire

[hw/rtl/fair_share_debt_update.sv]
// A load or clear entry is taken while the block is idle. The entry marked round end
// starts an update that runs over every slot, plus any wait on the result side; a new
// entry is taken only after the last result transfer. Each loaded runnable slot needs
// two passes of the shared divider while the runnable weight sum is nonzero, others one.
// Reset (rst_n low, synchronous) clears all debts, the loaded marks and sets total_priority to one.
`default_nettype none
`include "assert_macros.svh"
// ----------------------------------------------------------------------------
// fair_share_debt_update
// Fair-share debt update: long and short debts per project slot, computed
// by a sequencer around one shared divider.
// ----------------------------------------------------------------------------
module fair_share_debt_update
  import fsdu_pkg::*;
#(
  parameter int PROJECTS = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  fsdu_in_if.sink          in_ch,
  fsdu_out_if.source       out_ch,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [2:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int IDX_W = (PROJECTS > 1) ? $clog2(PROJECTS) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(PROJECTS - 1);
  localparam logic [2:0] ADDR_TP = 3'd0;

  typedef enum logic [3:0] {
    ST_IDLE, ST_SUM_RD, ST_SUM_ACC, ST_P1_RD, ST_P1_CHK, ST_P1_MUL, ST_P1_DIVL,
    ST_P1_DIVS, ST_P1_UPD, ST_MEAN, ST_MEAN_DIV, ST_P2_RD, ST_P2_EMIT, ST_OUT
  } state_t;

  state_t state_r;

  // Configuration register.
  logic [TP_W-1:0] tp_r;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == ADDR_TP) ? 32'(tp_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tp_r <= TP_W'(1);
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr == ADDR_TP) begin
      tp_r <= cfg_pwdata[TP_W-1:0];
    end
  end

  // Per-slot stores.
  ent_t                     ent_mem [PROJECTS];
  logic signed [LONG_W-1:0] long_mem [PROJECTS];
  logic signed [SHORT_W-1:0] short_mem [PROJECTS];
  logic signed [TMP_W-1:0]  tmp_mem [PROJECTS];
  ent_t                     ent_q;
  logic signed [LONG_W-1:0] long_q;
  logic signed [SHORT_W-1:0] short_q;
  logic signed [TMP_W-1:0]  tmp_q;

  logic [PROJECTS-1:0] loaded_r;
  logic [PROJECTS-1:0] used_vld_r;
  logic [PROJECTS-1:0] long_vld_r;
  logic [PROJECTS-1:0] short_vld_r;

  logic [IDX_W-1:0]         idx_r;
  logic [IDX_W-1:0]         last_r;
  logic [A_W-1:0]           a_r;
  logic [RW_W-1:0]          rw_r;
  logic [NRUN_W-1:0]        nrun_r;
  logic                     any_r;
  logic [DVSR_W-1:0]        dvsr_r;
  logic [PROD_W-1:0]        prod_r;
  logic [PROD_W-1:0]        earn_r;
  logic [A_W-1:0]           es_r;
  logic signed [TOT_W-1:0]  total_r;
  logic signed [TOT_W-1:0]  mean_r;
  logic                     neg_r;

  logic                     out_vld_r;
  logic [SLOT_W-1:0]        out_slot_r;
  logic signed [SHORT_W-1:0] out_short_r;
  logic signed [LONG_W-1:0] out_long_r;
  logic                     out_last_r;

  div_req_t div_req;
  div_rsp_t div_rsp;
  logic              div_go_r;
  logic [PROD_W-1:0] div_dvd_r;
  logic [DVSR_W-1:0] div_dvs_r;

  assign div_req.go       = div_go_r;
  assign div_req.dividend = div_dvd_r;
  assign div_req.divisor  = div_dvs_r;

  fsdu_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Write ports.
  logic                     in_xfer;
  logic                     slot_ok;
  logic                     ent_we;
  logic [IDX_W-1:0]         in_idx;
  ent_t                     ent_wd;
  logic                     upd_we;
  logic                     emit_we;
  logic                     last_xfer;

  assign in_xfer = in_ch.valid && in_ch.ready;
  assign slot_ok = (7'(in_ch.slot) < 7'(PROJECTS));
  assign in_idx  = IDX_W'(in_ch.slot);
  assign ent_we  = in_xfer && (in_ch.func == FUNC_LOAD) && slot_ok;
  assign ent_wd  = '{runnable: in_ch.runnable, weight: in_ch.share_weight,
                     used: in_ch.wall_time};
  assign upd_we  = (state_r == ST_P1_UPD);
  assign emit_we = (state_r == ST_P2_EMIT) && loaded_r[idx_r];
  assign last_xfer = out_vld_r && out_ch.ready && out_last_r;

  // Arithmetic of the update steps.
  logic [WALL_W-1:0]         used_eff;
  logic signed [LONG_W-1:0]  long_old;
  logic signed [SHORT_W-1:0] short_old;
  logic signed [LSUM_W-1:0]  long_sum;
  logic signed [LONG_W-1:0]  long_new;
  logic signed [TMP_W-1:0]   tmp_new;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [SHORT_W-1:0] short_new;
  logic [TOT_W-1:0]          total_mag;
  logic signed [TOT_W-1:0]   quo_s;

  always_comb begin
    used_eff  = used_vld_r[idx_r] ? ent_q.used : '0;
    long_old  = long_vld_r[idx_r] ? long_q : '0;
    short_old = short_vld_r[idx_r] ? short_q : '0;
    long_sum  = LSUM_W'(long_old) + $signed(LSUM_W'(earn_r)) - $signed(LSUM_W'(used_eff));
    if (long_sum > LONG_HI) begin
      long_new = LONG_HI[LONG_W-1:0];
    end else if (long_sum < LONG_LO) begin
      long_new = LONG_LO[LONG_W-1:0];
    end else begin
      long_new = long_sum[LONG_W-1:0];
    end
    if (ent_q.runnable) begin
      tmp_new = TMP_W'(short_old) + $signed(TMP_W'(es_r)) - $signed(TMP_W'(used_eff));
    end else begin
      tmp_new = '0;
    end
    diff = DIFF_W'(tmp_q) - DIFF_W'(mean_r);
    if (!ent_q.runnable) begin
      short_new = '0;
    end else if (diff > SHORT_HI) begin
      short_new = SHORT_HI[SHORT_W-1:0];
    end else if (diff < SHORT_LO) begin
      short_new = SHORT_LO[SHORT_W-1:0];
    end else begin
      short_new = diff[SHORT_W-1:0];
    end
    total_mag = (total_r < 0) ? TOT_W'(-total_r) : TOT_W'(total_r);
    quo_s     = $signed(div_rsp.quotient[TOT_W-1:0]);
  end

  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[in_idx] <= ent_wd;
    end
    if (upd_we) begin
      long_mem[idx_r] <= long_new;
      tmp_mem[idx_r]  <= tmp_new;
    end
    if (emit_we) begin
      short_mem[idx_r] <= short_new;
    end
    ent_q   <= ent_mem[idx_r];
    long_q  <= long_mem[idx_r];
    short_q <= short_mem[idx_r];
    tmp_q   <= tmp_mem[idx_r];
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      loaded_r    <= '0;
      used_vld_r  <= '0;
      long_vld_r  <= '0;
      short_vld_r <= '0;
      out_vld_r   <= 1'b0;
      div_go_r    <= 1'b0;
      idx_r       <= '0;
    end else begin
      div_go_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (in_xfer) begin
            if (in_ch.func == FUNC_CLEAR) begin
              short_vld_r <= '0;
              used_vld_r  <= '0;
            end else begin
              if (slot_ok) begin
                loaded_r[in_idx]   <= 1'b1;
                used_vld_r[in_idx] <= 1'b1;
              end
              if (in_ch.round_end) begin
                idx_r   <= '0;
                a_r     <= '0;
                rw_r    <= '0;
                nrun_r  <= '0;
                any_r   <= 1'b0;
                state_r <= ST_SUM_RD;
              end
            end
          end
        end
        ST_SUM_RD: state_r <= ST_SUM_ACC;
        ST_SUM_ACC: begin
          if (loaded_r[idx_r]) begin
            a_r    <= a_r + A_W'(used_eff);
            any_r  <= 1'b1;
            last_r <= idx_r;
            if (ent_q.runnable) begin
              rw_r   <= rw_r + RW_W'(ent_q.weight);
              nrun_r <= nrun_r + NRUN_W'(1);
            end
          end
          if (idx_r == LAST_IDX) begin
            idx_r   <= '0;
            dvsr_r  <= (tp_r == '0) ? DVSR_W'(1) : DVSR_W'(tp_r);
            total_r <= '0;
            // With no loaded slot the round ends without results.
            state_r <= (any_r || loaded_r[idx_r]) ? ST_P1_RD : ST_IDLE;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_SUM_RD;
          end
        end
        ST_P1_RD: state_r <= ST_P1_CHK;
        ST_P1_CHK: begin
          if (loaded_r[idx_r]) begin
            prod_r  <= a_r * ent_q.weight;
            state_r <= ST_P1_MUL;
          end else if (idx_r == LAST_IDX) begin
            state_r <= ST_MEAN;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_P1_RD;
          end
        end
        ST_P1_MUL: begin
          div_go_r  <= 1'b1;
          div_dvd_r <= prod_r;
          div_dvs_r <= dvsr_r;
          state_r   <= ST_P1_DIVL;
        end
        ST_P1_DIVL: begin
          if (div_rsp.done) begin
            earn_r <= div_rsp.quotient;
            if (ent_q.runnable && rw_r != '0) begin
              div_go_r  <= 1'b1;
              div_dvd_r <= prod_r;
              div_dvs_r <= DVSR_W'(rw_r);
              state_r   <= ST_P1_DIVS;
            end else begin
              es_r    <= '0;
              state_r <= ST_P1_UPD;
            end
          end
        end
        ST_P1_DIVS: begin
          if (div_rsp.done) begin
            es_r    <= div_rsp.quotient[A_W-1:0];
            state_r <= ST_P1_UPD;
          end
        end
        ST_P1_UPD: begin
          long_vld_r[idx_r] <= 1'b1;
          total_r <= total_r + TOT_W'(tmp_new);
          if (idx_r == LAST_IDX) begin
            state_r <= ST_MEAN;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_P1_RD;
          end
        end
        ST_MEAN: begin
          idx_r <= '0;
          if (nrun_r == '0) begin
            mean_r  <= '0;
            state_r <= ST_P2_RD;
          end else begin
            neg_r     <= (total_r < 0);
            div_go_r  <= 1'b1;
            div_dvd_r <= PROD_W'(total_mag);
            div_dvs_r <= DVSR_W'(nrun_r);
            state_r   <= ST_MEAN_DIV;
          end
        end
        ST_MEAN_DIV: begin
          if (div_rsp.done) begin
            mean_r  <= neg_r ? -quo_s : quo_s;
            state_r <= ST_P2_RD;
          end
        end
        ST_P2_RD: state_r <= ST_P2_EMIT;
        ST_P2_EMIT: begin
          if (loaded_r[idx_r]) begin
            loaded_r[idx_r]    <= 1'b0;
            used_vld_r[idx_r]  <= 1'b0;
            short_vld_r[idx_r] <= 1'b1;
            out_vld_r          <= 1'b1;
            out_slot_r         <= SLOT_W'(idx_r);
            out_short_r        <= short_new;
            out_long_r         <= long_q;
            out_last_r         <= (idx_r == last_r);
            state_r            <= ST_OUT;
          end else begin
            idx_r   <= idx_r + IDX_W'(1);
            state_r <= ST_P2_RD;
          end
        end
        ST_OUT: begin
          if (out_ch.ready) begin
            out_vld_r <= 1'b0;
            if (out_last_r) begin
              state_r <= ST_IDLE;
            end else begin
              idx_r   <= idx_r + IDX_W'(1);
              state_r <= ST_P2_RD;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_vld_r;
  assign out_ch.out_slot  = out_slot_r;
  assign out_ch.out_short = out_short_r;
  assign out_ch.out_long  = out_long_r;
  assign out_ch.last_out  = out_last_r;

  `FSDU_ASSERT_IMP(a_busy_not_ready, clk, rst_n, state_r != ST_IDLE, !in_ch.ready)
  `FSDU_ASSERT_IMP(a_out_in_out_state, clk, rst_n, out_vld_r, state_r == ST_OUT)
  `FSDU_ASSERT_IMP(a_div_start_idle, clk, rst_n, div_go_r, !div_rsp.busy)
  `FSDU_ASSERT_NXT(a_last_to_idle, clk, rst_n, last_xfer, state_r == ST_IDLE)

endmodule
`default_nettype wire

[hw/rtl/fsdu_div.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// fsdu_div
// Shared restoring divider, one quotient bit per cycle, unsigned operands.
// ----------------------------------------------------------------------------
module fsdu_div
  import fsdu_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic              busy_r;
  logic              done_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [PROD_W-1:0] quo_r;
  logic [DVSR_W-1:0] rem_r;
  logic [DVSR_W-1:0] dvs_r;

  logic [DVSR_W:0]   shifted;
  logic [DVSR_W:0]   diff;
  logic              ge;

  assign shifted = {rem_r, quo_r[PROD_W-1]};
  assign diff    = shifted - {1'b0, dvs_r};
  assign ge      = (shifted >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.go) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(PROD_W - 1);
        quo_r  <= req.dividend;
        rem_r  <= '0;
        dvs_r  <= req.divisor;
      end else if (busy_r) begin
        rem_r <= ge ? diff[DVSR_W-1:0] : shifted[DVSR_W-1:0];
        quo_r <= {quo_r[PROD_W-2:0], ge};
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == '0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule
`default_nettype wire
